FILE: hdl/twg_pkg.sv
package twg_pkg;

	typedef logic signed [31:0] gain_t;
	typedef logic [31:0] word_t;
	typedef logic [1:0] idx_t;
	typedef logic [2:0] reg_idx_t;
	typedef logic [16:0] coef_t;

	localparam int NumGains = 3;
	localparam int AddrW = 5;

	// gain slots
	localparam idx_t IDX_P = 2'd0;
	localparam idx_t IDX_I = 2'd1;
	localparam idx_t IDX_D = 2'd2;

	// register map (index = paddr[4:2])
	localparam reg_idx_t REG_GAIN_P = 3'd0;
	localparam reg_idx_t REG_GAIN_I = 3'd1;
	localparam reg_idx_t REG_GAIN_D = 3'd2;
	localparam reg_idx_t REG_STEP_P = 3'd3;
	localparam reg_idx_t REG_STEP_I = 3'd4;
	localparam reg_idx_t REG_STEP_D = 3'd5;
	localparam reg_idx_t REG_MIN_TOL = 3'd6;
	localparam reg_idx_t REG_BEST_ERR = 3'd7;

	// reset values
	localparam word_t RST_GAIN = 32'd0;
	localparam word_t RST_STEP_P = 32'd268435;   // 0.001 in Q4.28
	localparam word_t RST_STEP_I = 32'd13422;    // 0.00005 in Q4.28
	localparam word_t RST_STEP_D = 32'd268435;
	localparam word_t RST_MIN_TOL = 32'd0;
	localparam word_t RST_BEST_ERR = 32'd13757317; // 0.82 in Q8.24

	// step scale factors, unsigned Q1.16
	localparam coef_t K_GROW_FAST = 17'd72090;   // 1.1
	localparam coef_t K_GROW_SLOW = 17'd68813;   // 1.05
	localparam coef_t K_SHRINK = 17'd62259;      // 0.95

	localparam word_t GAIN_MAX = 32'h7FFF_FFFF;
	localparam word_t GAIN_MIN = 32'h8000_0000;
	localparam word_t STEP_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [NumGains-1:0][31:0] gain;
		logic [NumGains-1:0][31:0] step;
		word_t min_tol;
		word_t best_err;
	} cfg_t;

	typedef struct packed {
		logic [NumGains-1:0][31:0] gain;
		logic converged;
	} res_t;

	// gain + step, saturated to the signed 32 bit range
	function automatic word_t sat_add(input word_t g, input word_t s);
		logic [33:0] sum;
		begin
			sum = {{2{g[31]}}, g} + {2'b00, s};
			if (!sum[33] && (sum[32:31] != 2'b00)) begin
				sat_add = GAIN_MAX;
			end else begin
				sat_add = sum[31:0];
			end
		end
	endfunction

	// gain - 2*step, saturated
	function automatic word_t sat_sub2(input word_t g, input word_t s);
		logic [34:0] dif;
		begin
			dif = {{3{g[31]}}, g} - {2'b00, s, 1'b0};
			if (dif[34] && (dif[33:31] != 3'b111)) begin
				sat_sub2 = GAIN_MIN;
			end else begin
				sat_sub2 = dif[31:0];
			end
		end
	endfunction

	// round(step * k / 65536), half up, saturated
	function automatic word_t scale_step(input word_t s, input coef_t k);
		logic [48:0] prod;
		logic [32:0] rnd;
		begin
			prod = ({17'd0, s} * {32'd0, k}) + 49'd32768;
			rnd = prod[48:16];
			scale_step = rnd[32] ? STEP_MAX : rnd[31:0];
		end
	endfunction

endpackage

FILE: hdl/twg_regs.sv
module twg_regs
	import twg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output cfg_t             cfg,
	output logic             reload
);

	cfg_t cfg_q;
	logic reload_q;
	logic wr_en;
	reg_idx_t idx;

	assign wr_en = psel && penable && pwrite;
	assign idx = paddr[AddrW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain[0] <= RST_GAIN;
			cfg_q.gain[1] <= RST_GAIN;
			cfg_q.gain[2] <= RST_GAIN;
			cfg_q.step[0] <= RST_STEP_P;
			cfg_q.step[1] <= RST_STEP_I;
			cfg_q.step[2] <= RST_STEP_D;
			cfg_q.min_tol <= RST_MIN_TOL;
			cfg_q.best_err <= RST_BEST_ERR;
			reload_q <= 1'b0;
		end else begin
			reload_q <= wr_en;
			if (wr_en) begin
				case (idx)
					REG_GAIN_P: cfg_q.gain[0] <= pwdata;
					REG_GAIN_I: cfg_q.gain[1] <= pwdata;
					REG_GAIN_D: cfg_q.gain[2] <= pwdata;
					REG_STEP_P: cfg_q.step[0] <= pwdata;
					REG_STEP_I: cfg_q.step[1] <= pwdata;
					REG_STEP_D: cfg_q.step[2] <= pwdata;
					REG_MIN_TOL: cfg_q.min_tol <= pwdata;
					REG_BEST_ERR: cfg_q.best_err <= pwdata;
					default: cfg_q.best_err <= cfg_q.best_err;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_P: prdata = cfg_q.gain[0];
			REG_GAIN_I: prdata = cfg_q.gain[1];
			REG_GAIN_D: prdata = cfg_q.gain[2];
			REG_STEP_P: prdata = cfg_q.step[0];
			REG_STEP_I: prdata = cfg_q.step[1];
			REG_STEP_D: prdata = cfg_q.step[2];
			REG_MIN_TOL: prdata = cfg_q.min_tol;
			REG_BEST_ERR: prdata = cfg_q.best_err;
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;
	assign reload = reload_q;

endmodule

FILE: hdl/twg_core.sv
module twg_core
	import twg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  reload,
	input  logic  update,
	input  word_t error,
	output res_t  res
);

	logic [NumGains-1:0][31:0] gain_q, gain_d;
	logic [NumGains-1:0][31:0] step_q, step_d;
	word_t best_q, best_d;
	idx_t idx_q, idx_d;
	logic dec_q, dec_d;

	idx_t nxt;
	word_t cur_gain, cur_step, nxt_gain, nxt_step;
	word_t scaled, restored, backed, raised;
	coef_t k;
	logic [33:0] step_sum;
	logic conv, better;

	function automatic word_t pick(input logic [NumGains-1:0][31:0] arr, input idx_t i);
		begin
			case (i)
				IDX_P: pick = arr[0];
				IDX_I: pick = arr[1];
				IDX_D: pick = arr[2];
				default: pick = arr[0];
			endcase
		end
	endfunction

	always_comb begin
		step_sum = {2'b00, step_q[0]} + {2'b00, step_q[1]} + {2'b00, step_q[2]};
		conv = step_sum <= {2'b00, cfg.min_tol};
		better = error < best_q;
		nxt = (idx_q == IDX_D) ? IDX_P : idx_t'(idx_q + 2'd1);

		cur_gain = pick(gain_q, idx_q);
		cur_step = pick(step_q, idx_q);
		nxt_gain = pick(gain_q, nxt);
		nxt_step = pick(step_q, nxt);

		if (better) begin
			k = dec_q ? K_GROW_SLOW : K_GROW_FAST;
		end else begin
			k = K_SHRINK;
		end
		scaled = scale_step(cur_step, k);
		restored = sat_add(cur_gain, cur_step);
		backed = sat_sub2(cur_gain, cur_step);
		raised = sat_add(nxt_gain, nxt_step);

		gain_d = gain_q;
		step_d = step_q;
		best_d = best_q;
		idx_d = idx_q;
		dec_d = dec_q;

		if (update && !conv) begin
			if (better || dec_q) begin
				// new best, or second miss: settle this gain and move on
				for (int i = 0; i < NumGains; i++) begin
					if (idx_t'(i) == idx_q) begin
						step_d[i] = scaled;
						if (!better) begin
							gain_d[i] = restored;
						end
					end
					if (idx_t'(i) == nxt) begin
						gain_d[i] = raised;
					end
				end
				if (better) begin
					best_d = error;
				end
				idx_d = nxt;
				dec_d = 1'b0;
			end else begin
				// first miss: try the other direction
				for (int i = 0; i < NumGains; i++) begin
					if (idx_t'(i) == idx_q) begin
						gain_d[i] = backed;
					end
				end
				dec_d = 1'b1;
			end
		end

		res.gain = gain_d;
		res.converged = conv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0] <= RST_GAIN;
			gain_q[1] <= RST_GAIN;
			gain_q[2] <= RST_GAIN;
			step_q[0] <= RST_STEP_P;
			step_q[1] <= RST_STEP_I;
			step_q[2] <= RST_STEP_D;
			best_q <= RST_BEST_ERR;
			idx_q <= IDX_P;
			dec_q <= 1'b0;
		end else if (reload) begin
			gain_q <= cfg.gain;
			step_q <= cfg.step;
			best_q <= cfg.best_err;
			idx_q <= IDX_P;
			dec_q <= 1'b0;
		end else begin
			gain_q <= gain_d;
			step_q <= step_d;
			best_q <= best_d;
			idx_q <= idx_d;
			dec_q <= dec_d;
		end
	end

endmodule

FILE: hdl/twiddle_gain_tuner.sv
// Twiddle tuner for three PID gains (P, I, D), Q4.28 signed gains.
// Error channel: error (Q8.24) with error_valid / error_ready; one
// transaction per measured run. Result channel: gain_p, gain_i, gain_d,
// converged with result_valid / result_ready; exactly one result
// transaction per error transaction, in order.
// Pipeline: two register stages (input register, then result register);
// a result loads when its error leaves the input register; the error waits
// there while a result is stalled. Throughput: one transaction per cycle
// while result_ready is high; the gain/step/best-error state loop closes
// around a single 32x17 step-scaling multiply and the saturating adds.
// When result_ready is low a valid result register holds; one more error
// transaction is taken into the input register, then error_ready drops.
// Configuration: APB-style, registers at byte addresses 4*i (i = 0..7),
// pready always high, reads return the register. Any write reloads the
// tuning state from the registers in the cycle after it; write only while idle.
// Reset (arst_n low): registers and state take their defaults (step P/D
// 0.001, step I 0.00005, best error 0.82, gains and tolerance zero),
// both pipeline stages empty.
module twiddle_gain_tuner
	import twg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [AddrW-1:0]   paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// error channel
	input  logic               error_valid,
	output logic               error_ready,
	input  logic [31:0]        error,
	// result channel
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] gain_p,
	output logic signed [31:0] gain_i,
	output logic signed [31:0] gain_d,
	output logic               converged
);

	cfg_t cfg;
	logic reload;
	res_t res;

	word_t error_s1;
	logic valid_s1;
	res_t res_s2;
	logic valid_s2;
	logic advance;

	twg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg),
		.reload (reload)
	);

	// state update happens on the same edge the result register loads
	twg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.reload (reload),
		.update (advance),
		.error  (error_s1),
		.res    (res)
	);

	assign pready = 1'b1;

	// stage 1 moves on whenever the result register is free or being drained
	assign advance = valid_s1 && (!valid_s2 || result_ready);
	assign error_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (error_valid && error_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (error_valid && error_ready) begin
			error_s1 <= error;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign gain_p = res_s2.gain[0];
	assign gain_i = res_s2.gain[1];
	assign gain_d = res_s2.gain[2];
	assign converged = res_s2.converged;

endmodule

FILE: hdl/twg_checker.sv
module twg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pready,
	input logic               error_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic signed [31:0] gain_p,
	input logic signed [31:0] gain_i,
	input logic signed [31:0] gain_d,
	input logic               converged
);

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(gain_p)
		&& $stable(gain_i) && $stable(gain_d) && $stable(converged))
		else $error("result changed while stalled");

	// error side backs up only behind a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!error_ready |-> result_valid && !result_ready)
		else $error("error_ready low without a stalled result");

	// a full pipeline behind a stalled result opens only when the receiver takes it
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!error_ready && !result_ready |=> result_valid && (!error_ready || result_ready))
		else $error("error_ready rose while pipeline still blocked");

	// config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("pready low during access");

endmodule

bind twiddle_gain_tuner twg_checker u_twg_checker (.*);
